// ===== rtl/sfcd_pkg.sv =====
// ----------------------------------------------------------------------------
// sfcd_pkg
// Shared types, constants and the CRC-16/MODBUS byte update for the sensor
// frame decoder.
// ----------------------------------------------------------------------------
package sfcd_pkg;

  localparam int unsigned PosW = 3;

  typedef logic [PosW-1:0] pos_t;

  // byte positions within one 8-byte response frame
  localparam pos_t POS_HDR0    = 3'd0;
  localparam pos_t POS_HDR1    = 3'd1;
  localparam pos_t POS_HUM_HI  = 3'd2;
  localparam pos_t POS_HUM_LO  = 3'd3;
  localparam pos_t POS_TMP_HI  = 3'd4;
  localparam pos_t POS_TMP_LO  = 3'd5;
  localparam pos_t POS_CRC_LO  = 3'd6;
  localparam pos_t POS_CRC_HI  = 3'd7;

  localparam logic [15:0] CrcInit = 16'hFFFF;
  localparam logic [15:0] CrcPoly = 16'hA001;

  typedef struct packed {
    logic        [15:0] humidity_tenths;
    logic signed [15:0] temperature_tenths;
    logic               crc_ok;
  } res_t;

  // reflected CRC-16, one byte, LSB first
  function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CrcPoly;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

// ===== rtl/sfcd_in_if.sv =====
// ----------------------------------------------------------------------------
// sfcd_in_if
// Byte channel into the decoder: valid/ready with one response byte a beat.
// ----------------------------------------------------------------------------
interface sfcd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  logic       frame_start;

  modport source (output valid, output rx_byte, output frame_start, input ready);
  modport sink   (input valid, input rx_byte, input frame_start, output ready);
endinterface

// ===== rtl/sfcd_out_if.sv =====
// ----------------------------------------------------------------------------
// sfcd_out_if
// Result channel out of the decoder: valid/ready with one decoded frame a beat.
// ----------------------------------------------------------------------------
interface sfcd_out_if;
  logic               valid;
  logic               ready;
  logic        [15:0] humidity_tenths;
  logic signed [15:0] temperature_tenths;
  logic               crc_ok;

  modport source (output valid, output humidity_tenths, output temperature_tenths,
                  output crc_ok, input ready);
  modport sink   (input valid, input humidity_tenths, input temperature_tenths,
                  input crc_ok, output ready);
endinterface

// ===== rtl/sfcd_frame.sv =====
// ----------------------------------------------------------------------------
// sfcd_frame
// Frame state: byte position, running CRC and captured fields. Consumes one
// byte per step and forms the result when the last byte arrives.
// ----------------------------------------------------------------------------
module sfcd_frame (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             step_i,
  input  logic [7:0]       rx_byte_i,
  input  logic             frame_start_i,
  output logic             last_o,
  output sfcd_pkg::res_t   res_o
);
  import sfcd_pkg::*;

  pos_t        pos_q, pos_d, pos_cur;
  logic [15:0] crc_q, crc_d, crc_base;
  logic [15:0] hum_q, hum_d;
  logic [15:0] tmp_q, tmp_d;
  logic [7:0]  crc_lo_q, crc_lo_d;
  logic [15:0] mag;

  assign pos_cur  = frame_start_i ? POS_HDR0 : pos_q;
  assign crc_base = (pos_cur == POS_HDR0) ? CrcInit : crc_q;
  assign last_o   = (pos_cur == POS_CRC_HI);

  always_comb begin
    pos_d    = pos_cur + pos_t'(1);
    crc_d    = crc_q;
    hum_d    = hum_q;
    tmp_d    = tmp_q;
    crc_lo_d = crc_lo_q;
    case (pos_cur)
      POS_HDR0, POS_HDR1: begin
        crc_d = crc16_byte(crc_base, rx_byte_i);
      end
      POS_HUM_HI: begin
        crc_d = crc16_byte(crc_base, rx_byte_i);
        hum_d = {rx_byte_i, hum_q[7:0]};
      end
      POS_HUM_LO: begin
        crc_d = crc16_byte(crc_base, rx_byte_i);
        hum_d = {hum_q[15:8], rx_byte_i};
      end
      POS_TMP_HI: begin
        crc_d = crc16_byte(crc_base, rx_byte_i);
        tmp_d = {rx_byte_i, tmp_q[7:0]};
      end
      POS_TMP_LO: begin
        crc_d = crc16_byte(crc_base, rx_byte_i);
        tmp_d = {tmp_q[15:8], rx_byte_i};
      end
      POS_CRC_LO: begin
        crc_lo_d = rx_byte_i;
      end
      default: begin
      end
    endcase
  end

  // sign-magnitude to two's complement; negative zero comes out as zero
  assign mag = {1'b0, tmp_q[14:0]};

  always_comb begin
    res_o.humidity_tenths    = hum_q;
    res_o.temperature_tenths = tmp_q[15] ? signed'(16'h0000 - mag) : signed'(mag);
    res_o.crc_ok             = (crc_q == {rx_byte_i, crc_lo_q});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q    <= POS_HDR0;
      crc_q    <= CrcInit;
      hum_q    <= '0;
      tmp_q    <= '0;
      crc_lo_q <= '0;
    end else if (step_i) begin
      pos_q    <= pos_d;
      crc_q    <= crc_d;
      hum_q    <= hum_d;
      tmp_q    <= tmp_d;
      crc_lo_q <= crc_lo_d;
    end
  end

  a_last_wraps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && last_o |=> pos_q == POS_HDR0)
    else $error("position did not wrap after last byte");

  a_start_restarts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && frame_start_i |=> pos_q == POS_HDR1)
    else $error("frame start did not restart position");

  a_hold_when_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !step_i |=> $stable(pos_q) && $stable(crc_q))
    else $error("frame state moved without a step");

endmodule

// ===== rtl/sfcd_in_stage.sv =====
// ----------------------------------------------------------------------------
// sfcd_in_stage
// Input register for one byte beat; holds it until the frame logic consumes it.
// ----------------------------------------------------------------------------
module sfcd_in_stage (
  input  logic       clk_i,
  input  logic       rst_ni,
  sfcd_in_if.sink    rx_i,
  input  logic       take_i,
  output logic       valid_o,
  output logic [7:0] rx_byte_o,
  output logic       frame_start_o
);
  import sfcd_pkg::*;

  logic       valid_q;
  logic [7:0] byte_q;
  logic       start_q;
  logic       load;

  assign rx_i.ready = !valid_q || take_i;
  assign load       = rx_i.valid && rx_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load) begin
      valid_q <= 1'b1;
    end else if (take_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      byte_q  <= rx_i.rx_byte;
      start_q <= rx_i.frame_start;
    end
  end

  assign valid_o       = valid_q;
  assign rx_byte_o     = byte_q;
  assign frame_start_o = start_q;

  a_take_needs_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take_i |-> valid_q)
    else $error("byte consumed from empty input register");

  a_held_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q && !take_i |=> valid_q && $stable(byte_q) && $stable(start_q))
    else $error("pending byte lost or changed");

  a_load_sets_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load |=> valid_q)
    else $error("accepted beat not registered");

endmodule

// ===== rtl/sensor_frame_crc_decoder_core.sv =====
// ----------------------------------------------------------------------------
// sensor_frame_crc_decoder_core
// Sensor response frame decoder with CRC-16/MODBUS check.
//
//   channel  dir  fields                                            beats
//   rx_i     in   rx_byte[7:0], frame_start                         1 per byte
//   res_o    out  humidity_tenths[15:0], temperature_tenths[15:0],  1 per 8 bytes
//                 crc_ok
//
// One byte beat per cycle sustained while the result is not stalled. A byte
// is registered in the input register, then its CRC update and field capture
// run into the frame state; the eighth byte also loads the result register.
// Reset clears position, CRC (to 0xFFFF) and both valid flags.
// A stalled result holds the eighth byte of the next frame, which back-pressures rx_i.
// ----------------------------------------------------------------------------
module sensor_frame_crc_decoder_core (
  input  logic      clk_i,
  input  logic      rst_ni,
  sfcd_in_if.sink   rx_i,
  sfcd_out_if.source res_o
);
  import sfcd_pkg::*;

  logic       s1_valid;
  logic [7:0] s1_byte;
  logic       s1_start;
  logic       s1_last;
  logic       s1_take;
  logic       out_free;
  logic       res_load;
  res_t       res_next;
  res_t       res_q;
  logic       res_valid_q;

  sfcd_in_stage u_in_stage (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .rx_i          (rx_i),
    .take_i        (s1_take),
    .valid_o       (s1_valid),
    .rx_byte_o     (s1_byte),
    .frame_start_o (s1_start)
  );

  sfcd_frame u_frame (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .step_i        (s1_take),
    .rx_byte_i     (s1_byte),
    .frame_start_i (s1_start),
    .last_o        (s1_last),
    .res_o         (res_next)
  );

  assign out_free = !res_valid_q || res_o.ready;
  assign s1_take  = s1_valid && (!s1_last || out_free);
  assign res_load = s1_take && s1_last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (res_load) begin
      res_valid_q <= 1'b1;
    end else if (res_o.ready) begin
      res_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_load) begin
      res_q <= res_next;
    end
  end

  assign res_o.valid              = res_valid_q;
  assign res_o.humidity_tenths    = res_q.humidity_tenths;
  assign res_o.temperature_tenths = res_q.temperature_tenths;
  assign res_o.crc_ok             = res_q.crc_ok;

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_load |-> !(res_valid_q && !res_o.ready))
    else $error("result register overwritten while stalled");

  a_load_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_load |=> res_valid_q)
    else $error("loaded result not presented");

  a_result_only_on_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(res_valid_q) |-> $past(s1_take) && $past(s1_last))
    else $error("result raised without a final byte");

endmodule
